// ===== design/lprq_pkg.sv =====
package lprq_pkg;

  // Default ring size in bytes
  localparam int DEPTH_DEFAULT = 1024;

  // Field widths of the command and result beats
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_REFUSED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NEAR_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ZERO_LEN   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_SHORT      = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_STRAY      = 3'd5;

endpackage

// ===== design/length_prefixed_byte_ring_queue.sv =====
// Byte ring queue for length-prefixed messages. Each command beat (push byte,
// pop byte, clear) is taken when start is high while busy is low, and yields
// exactly one result beat, shown for a single cycle with done high; the
// receiver cannot stall it, so it must capture the result when done is seen.
// For every command, the byte at the read pointer is fetched from the
// synchronous byte store (one write port, one read port) at the accepting
// edge, the first cycle (state S_RUN) decides, writes the store and updates
// the pointers, and the result registers then show the result. busy is high
// during the first cycle, so a new command may follow every other cycle, and
// done for one command coincides with the cycle in which the next may be
// taken. No clearing pass is needed after reset.
module length_prefixed_byte_ring_queue #(
  parameter int DEPTH = lprq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lprq_pkg::OP_W-1:0]          opcode,
  input  logic [lprq_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               first_of_chunk,
  input  logic [lprq_pkg::LEN_W-1:0]         chunk_length,
  output logic                               done,
  output logic [lprq_pkg::STATUS_W-1:0]      status,
  output logic [lprq_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_valid,
  output logic                               last_of_message,
  output logic [lprq_pkg::COUNT_W-1:0]       used_count,
  output logic [lprq_pkg::COUNT_W-1:0]       free_count_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + lprq_pkg::LEN_W;
  localparam int LW = lprq_pkg::LEN_W;
  localparam int BW = lprq_pkg::BYTE_W;
  localparam int PW = BW;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;

  // Latched command beat
  logic [lprq_pkg::OP_W-1:0] op_q;
  logic [BW-1:0]             byte_q;
  logic                      first_q;
  logic [LW-1:0]             len_q;

  // Ring state
  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] rd_data;
  logic [AW-1:0] write_index, write_index_next;
  logic [AW-1:0] read_index, read_index_next;
  logic [CW-1:0] free_slots, free_slots_next;
  logic [LW-1:0] push_remaining, push_remaining_next;
  logic          push_dropping, push_dropping_next;
  logic [PW-1:0] pop_remaining, pop_remaining_next;

  // Per-command decisions
  logic                          mem_we;
  logic [lprq_pkg::STATUS_W-1:0] status_next;
  logic [BW-1:0]                 out_byte_next;
  logic                          out_valid_next;
  logic                          last_next;

  logic          accept;
  logic [CW-1:0] used_now;
  logic [CW-1:0] used_after;
  logic [XW-1:0] free_x;
  logic [XW-1:0] len_x;
  logic [XW-1:0] used_x;
  logic [XW-1:0] head_len_x;
  logic [XW-1:0] used_out_x;
  logic [XW-1:0] free_out_x;

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;

  // Store: one write, one registered read at the read pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_index] <= byte_q;
    end
    rd_data <= mem[read_index];
  end

  // Widened operands for compares
  assign used_now   = DEPTH_C - free_slots;
  assign free_x     = XW'(free_slots);
  assign len_x      = XW'(len_q);
  assign used_x     = XW'(used_now);
  assign head_len_x = XW'(rd_data);

  // Command evaluation
  always_comb begin
    write_index_next    = write_index;
    read_index_next     = read_index;
    free_slots_next     = free_slots;
    push_remaining_next = push_remaining;
    push_dropping_next  = push_dropping;
    pop_remaining_next  = pop_remaining;
    mem_we              = 1'b0;
    status_next         = lprq_pkg::STAT_OK;
    out_byte_next       = '0;
    out_valid_next      = 1'b0;
    last_next           = 1'b0;

    if (state == S_RUN) begin
      case (op_q)
        lprq_pkg::OP_PUSH: begin
          if (first_q) begin
            if (len_q == '0) begin
              push_remaining_next = '0;
              push_dropping_next  = 1'b0;
              status_next         = lprq_pkg::STAT_REFUSED;
            end else begin
              push_remaining_next = len_q - LW'(1);
              if (free_x > XW'(2) && free_x >= len_x) begin
                push_dropping_next = 1'b0;
                mem_we             = 1'b1;
              end else begin
                push_dropping_next = 1'b1;
                status_next        = lprq_pkg::STAT_REFUSED;
              end
            end
          end else if (push_remaining == '0) begin
            status_next = lprq_pkg::STAT_STRAY;
          end else begin
            push_remaining_next = push_remaining - LW'(1);
            if (push_dropping) begin
              status_next = lprq_pkg::STAT_REFUSED;
            end else if (free_slots == '0) begin
              push_dropping_next = 1'b1;
              status_next        = lprq_pkg::STAT_REFUSED;
            end else begin
              mem_we = 1'b1;
            end
          end
          if (mem_we) begin
            write_index_next = (write_index == LAST_SLOT) ? '0 : write_index + AW'(1);
            free_slots_next  = free_slots - CW'(1);
          end
        end
        lprq_pkg::OP_POP: begin
          if (pop_remaining == '0) begin
            if (used_x < XW'(2)) begin
              status_next = lprq_pkg::STAT_NEAR_EMPTY;
            end else if (rd_data == '0) begin
              status_next = lprq_pkg::STAT_ZERO_LEN;
            end else if (head_len_x > used_x) begin
              status_next = lprq_pkg::STAT_SHORT;
            end else begin
              out_valid_next     = 1'b1;
              pop_remaining_next = rd_data - PW'(1);
              last_next          = (rd_data == PW'(1));
            end
          end else if (used_now == '0) begin
            pop_remaining_next = '0;
            status_next        = lprq_pkg::STAT_NEAR_EMPTY;
          end else begin
            out_valid_next     = 1'b1;
            pop_remaining_next = pop_remaining - PW'(1);
            last_next          = (pop_remaining == PW'(1));
          end
          if (out_valid_next) begin
            out_byte_next   = rd_data;
            read_index_next = (read_index == LAST_SLOT) ? '0 : read_index + AW'(1);
            free_slots_next = free_slots + CW'(1);
          end
        end
        lprq_pkg::OP_CLEAR: begin
          write_index_next    = '0;
          read_index_next     = '0;
          free_slots_next     = DEPTH_C;
          push_remaining_next = '0;
          push_dropping_next  = 1'b0;
          pop_remaining_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Counts reported masked to the result field width
  assign used_after = DEPTH_C - free_slots_next;
  assign used_out_x = XW'(used_after);
  assign free_out_x = XW'(free_slots_next);

  // Sequencer and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_index    <= '0;
      read_index     <= '0;
      free_slots     <= DEPTH_C;
      push_remaining <= '0;
      push_dropping  <= 1'b0;
      pop_remaining  <= '0;
      done           <= 1'b0;
    end else begin
      write_index    <= write_index_next;
      read_index     <= read_index_next;
      free_slots     <= free_slots_next;
      push_remaining <= push_remaining_next;
      push_dropping  <= push_dropping_next;
      pop_remaining  <= pop_remaining_next;
      done           <= (state == S_RUN);
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      byte_q  <= data_byte;
      first_q <= first_of_chunk;
      len_q   <= chunk_length;
    end
    if (state == S_RUN) begin
      status          <= status_next;
      out_byte        <= out_byte_next;
      out_valid       <= out_valid_next;
      last_of_message <= last_next;
      used_count      <= used_out_x[lprq_pkg::COUNT_W-1:0];
      free_count_out  <= free_out_x[lprq_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== bench/length_prefixed_byte_ring_queue_test.sv =====
`timescale 1ns / 1ps

module length_prefixed_byte_ring_queue_test;

  localparam int OP_W     = lprq_pkg::OP_W;
  localparam int BYTE_W   = lprq_pkg::BYTE_W;
  localparam int LEN_W    = lprq_pkg::LEN_W;
  localparam int STATUS_W = lprq_pkg::STATUS_W;
  localparam int COUNT_W  = lprq_pkg::COUNT_W;

  localparam int RING_DEPTH = lprq_pkg::DEPTH_DEFAULT;
  localparam int BEAT_TARGET = 1850;
  localparam int CYCLE_LIMIT = 500000;
  // Opcode 3 has no package name; the block ignores it
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              lead;
    logic [LEN_W-1:0]  len;
  } ring_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   obyte;
    logic                ovalid;
    logic                olast;
    logic [COUNT_W-1:0]  used;
    logic [COUNT_W-1:0]  free;
  } ring_result_t;

  typedef struct {
    ring_cmd_t    cmd;
    bit           typed;
    ring_result_t want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     opcode;
  logic [BYTE_W-1:0]   data_byte;
  logic                first_of_chunk;
  logic [LEN_W-1:0]    chunk_length;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_valid;
  logic                last_of_message;
  logic [COUNT_W-1:0]  used_count;
  logic [COUNT_W-1:0]  free_count_out;

  length_prefixed_byte_ring_queue dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .data_byte       (data_byte),
    .first_of_chunk  (first_of_chunk),
    .chunk_length    (chunk_length),
    .done            (done),
    .status          (status),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .last_of_message (last_of_message),
    .used_count      (used_count),
    .free_count_out  (free_count_out)
  );

  // Queue shadow state
  logic [7:0] ring_mem [RING_DEPTH];
  int ring_wr;
  int ring_rd;
  int ring_free;
  int chunk_left;
  bit chunk_drop;
  int msg_left;

  ring_result_t pending_results [$];
  ring_result_t last_outcome;
  dir_row_t     dir_rows [$];
  int           mismatches = 0;
  int           beats_sent;
  int           cycle_count = 0;
  bit           steady_run;

  always #5 clk = ~clk;

  function automatic void put_byte(logic [7:0] b);
    ring_mem[ring_wr] = b;
    ring_wr = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;
    ring_free--;
  endfunction

  function automatic logic [7:0] take_byte();
    logic [7:0] b;
    b = ring_mem[ring_rd];
    ring_rd = (ring_rd + 1 >= RING_DEPTH) ? 0 : ring_rd + 1;
    ring_free++;
    return b;
  endfunction

  // Next queue outcome for one command beat; advances the shadow state
  function automatic ring_result_t queue_outcome(ring_cmd_t c);
    ring_result_t r;
    int used;
    int hlen;
    r = '0;
    r.status = lprq_pkg::STAT_OK;
    used = RING_DEPTH - ring_free;
    case (c.op)
      lprq_pkg::OP_PUSH: begin
        if (c.lead) begin
          if (c.len == 0) begin
            chunk_left = 0;
            chunk_drop = 0;
            r.status = lprq_pkg::STAT_REFUSED;
          end else begin
            chunk_left = int'(c.len) - 1;
            if (ring_free > 2 && ring_free >= int'(c.len)) begin
              chunk_drop = 0;
              put_byte(c.data);
            end else begin
              chunk_drop = 1;
              r.status = lprq_pkg::STAT_REFUSED;
            end
          end
        end else if (chunk_left == 0) begin
          r.status = lprq_pkg::STAT_STRAY;
        end else begin
          chunk_left--;
          if (chunk_drop) begin
            r.status = lprq_pkg::STAT_REFUSED;
          end else if (ring_free == 0) begin
            chunk_drop = 1;
            r.status = lprq_pkg::STAT_REFUSED;
          end else begin
            put_byte(c.data);
          end
        end
      end
      lprq_pkg::OP_POP: begin
        if (msg_left == 0) begin
          if (used < 2) begin
            r.status = lprq_pkg::STAT_NEAR_EMPTY;
          end else begin
            hlen = ring_mem[ring_rd];
            if (hlen == 0) begin
              r.status = lprq_pkg::STAT_ZERO_LEN;
            end else if (hlen > used) begin
              r.status = lprq_pkg::STAT_SHORT;
            end else begin
              r.obyte = take_byte();
              r.ovalid = 1'b1;
              msg_left = hlen - 1;
              r.olast = (msg_left == 0);
            end
          end
        end else if (used == 0) begin
          msg_left = 0;
          r.status = lprq_pkg::STAT_NEAR_EMPTY;
        end else begin
          r.obyte = take_byte();
          r.ovalid = 1'b1;
          msg_left--;
          r.olast = (msg_left == 0);
        end
      end
      lprq_pkg::OP_CLEAR: begin
        ring_wr = 0;
        ring_rd = 0;
        ring_free = RING_DEPTH;
        chunk_left = 0;
        chunk_drop = 0;
        msg_left = 0;
      end
      default: ;
    endcase
    r.used = COUNT_W'(RING_DEPTH - ring_free);
    r.free = COUNT_W'(ring_free);
    return r;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_miss(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Drive one command beat and queue what it should return
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                          input logic lead, input logic [LEN_W-1:0] len,
                          input bit typed = 1'b0, input ring_result_t want = '0);
    ring_cmd_t c;
    int gap;
    c = {op, data, lead, len};
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = op;
    data_byte = data;
    first_of_chunk = lead;
    chunk_length = len;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_outcome = queue_outcome(c);
    pending_results.push_back(typed ? want : last_outcome);
    if (op != OP_NOP) beats_sent++;
  endtask

  // Well-formed message: length byte first, chunk covers the whole message
  task automatic push_message(int mlen);
    send_cmd(lprq_pkg::OP_PUSH, BYTE_W'(mlen), 1'b1, LEN_W'(mlen));
    for (int i = 1; i < mlen; i++)
      send_cmd(lprq_pkg::OP_PUSH, BYTE_W'($urandom), 1'b0, LEN_W'($urandom_range(0, 2047)));
  endtask

  task automatic pop_burst(int n);
    for (int i = 0; i < n; i++) begin
      send_cmd(lprq_pkg::OP_POP, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      // a jammed head is sometimes cleared here with a clear beat
      if ((last_outcome.status == lprq_pkg::STAT_ZERO_LEN ||
           last_outcome.status == lprq_pkg::STAT_SHORT) &&
          $urandom_range(0, 1) == 1) begin
        send_cmd(lprq_pkg::OP_CLEAR, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
        break;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(logic [OP_W-1:0] op, logic [7:0] data, logic lead,
                                  logic [LEN_W-1:0] len, bit typed = 1'b0,
                                  logic [STATUS_W-1:0] st = lprq_pkg::STAT_OK,
                                  int used = 0, int free = 0);
    dir_row_t row;
    row.cmd = {op, data, lead, len};
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.used = COUNT_W'(used);
    row.want.free = COUNT_W'(free);
    dir_rows.push_back(row);
  endfunction

  // Result checker
  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        log_miss("result beat with no command pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          log_miss($sformatf("status: expected %0d, got %0d", want.status, status));
        if (out_byte !== want.obyte)
          log_miss($sformatf("out_byte: expected %0h, got %0h", want.obyte, out_byte));
        if (out_valid !== want.ovalid)
          log_miss($sformatf("out_valid: expected %0d, got %0d", want.ovalid, out_valid));
        if (last_of_message !== want.olast)
          log_miss($sformatf("last_of_message: expected %0d, got %0d", want.olast,
                             last_of_message));
        if (used_count !== want.used)
          log_miss($sformatf("used_count: expected %0d, got %0d", want.used, used_count));
        if (free_count_out !== want.free)
          log_miss($sformatf("free_count_out: expected %0d, got %0d", want.free,
                             free_count_out));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int roll;
    int fill_left;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    opcode = lprq_pkg::OP_PUSH;
    data_byte = '0;
    first_of_chunk = 1'b0;
    chunk_length = '0;
    beats_sent = 0;
    steady_run = 1'b0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_wr = 0;
    ring_rd = 0;
    ring_free = RING_DEPTH;
    chunk_left = 0;
    chunk_drop = 0;
    msg_left = 0;

    // Directed table: typed expectations where they are obvious
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0,    1, lprq_pkg::STAT_NEAR_EMPTY, 0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'hFF, 1'b0, 11'd0,    1, lprq_pkg::STAT_STRAY,      0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'h5A, 1'b1, 11'd0,    1, lprq_pkg::STAT_REFUSED,    0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'hFF, 1'b1, 11'd2047, 1, lprq_pkg::STAT_REFUSED,    0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'h00, 1'b0, 11'd0,    1, lprq_pkg::STAT_REFUSED,    0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'h77, 1'b1, 11'd1025, 1, lprq_pkg::STAT_REFUSED,    0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'h03, 1'b1, 11'd3,    1, lprq_pkg::STAT_OK,         1, 1023);
    add_row(lprq_pkg::OP_PUSH,  8'hAA, 1'b0, 11'h7FF);
    add_row(lprq_pkg::OP_PUSH,  8'h55, 1'b0, 11'd0);
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0);
    add_row(lprq_pkg::OP_POP,   8'hFF, 1'b1, 11'h7FF);
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0);
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0,    1, lprq_pkg::STAT_NEAR_EMPTY, 0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'h00, 1'b1, 11'd1,    1, lprq_pkg::STAT_OK,         1, 1023);
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0,    1, lprq_pkg::STAT_NEAR_EMPTY, 1, 1023);
    add_row(lprq_pkg::OP_PUSH,  8'h80, 1'b1, 11'd1);
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0,    1, lprq_pkg::STAT_ZERO_LEN,   2, 1022);
    add_row(lprq_pkg::OP_CLEAR, 8'hFF, 1'b1, 11'h7FF,  1, lprq_pkg::STAT_OK,         0, 1024);
    add_row(lprq_pkg::OP_PUSH,  8'h05, 1'b1, 11'd2);
    add_row(lprq_pkg::OP_PUSH,  8'h09, 1'b0, 11'd0);
    add_row(lprq_pkg::OP_POP,   8'h00, 1'b0, 11'd0,    1, lprq_pkg::STAT_SHORT,      2, 1022);
    // a new chunk opened inside an open one
    add_row(lprq_pkg::OP_PUSH,  8'h04, 1'b1, 11'd4);
    add_row(lprq_pkg::OP_PUSH,  8'h11, 1'b0, 11'd0);
    add_row(lprq_pkg::OP_PUSH,  8'h02, 1'b1, 11'd2);
    add_row(lprq_pkg::OP_PUSH,  8'hEE, 1'b0, 11'd0);
    add_row(OP_NOP,             8'hFF, 1'b1, 11'h7FF,  1, lprq_pkg::STAT_OK,         6, 1018);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd.op, dir_rows[i].cmd.data, dir_rows[i].cmd.lead,
               dir_rows[i].cmd.len, dir_rows[i].typed, dir_rows[i].want);

    // Fill the ring with long messages up to the free-space threshold
    send_cmd(lprq_pkg::OP_CLEAR, 8'h00, 1'b0, 11'd0);
    while (ring_free > 257) begin
      if ($urandom_range(0, 19) == 0) steady_run = ~steady_run;
      push_message($urandom_range(200, 255));
    end
    push_message(ring_free - 2);
    // two free slots: refused even when the chunk would fit
    send_cmd(lprq_pkg::OP_PUSH, 8'h02, 1'b1, 11'd2);
    send_cmd(lprq_pkg::OP_PUSH, BYTE_W'($urandom), 1'b0, 11'd0);
    send_cmd(lprq_pkg::OP_PUSH, 8'h01, 1'b1, 11'd1);
    pop_burst(260);
    send_cmd(lprq_pkg::OP_PUSH, 8'h03, 1'b1, LEN_W'(ring_free + 1));
    push_message(3);

    // Hold off until the block has answered everything
    drain_results();
    steady_run = 1'b0;
    send_cmd(lprq_pkg::OP_CLEAR, 8'h00, 1'b0, 11'd0);

    // Random mix: mostly well-formed messages and pops, some noise
    while (beats_sent < BEAT_TARGET) begin
      if ($urandom_range(0, 29) == 0) steady_run = ~steady_run;
      roll = $urandom_range(0, 99);
      if (RING_DEPTH - ring_free > 700) roll = 50;
      if (roll < 45) begin
        fill_left = $urandom_range(0, 99);
        if (fill_left < 85) push_message($urandom_range(2, 10));
        else if (fill_left < 95) push_message($urandom_range(1, 40));
        else push_message($urandom_range(41, 255));
      end else if (roll < 75) begin
        pop_burst($urandom_range(1, 12));
      end else if (roll < 81) begin
        // broken chunk: random length, random number of trailing bytes
        send_cmd(lprq_pkg::OP_PUSH, BYTE_W'($urandom), 1'b1,
                 ($urandom_range(0, 1) == 1) ? LEN_W'($urandom_range(0, 8))
                                              : LEN_W'($urandom_range(0, 2047)));
        repeat ($urandom_range(0, 10))
          send_cmd(lprq_pkg::OP_PUSH, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
      end else if (roll < 86) begin
        // chunk abandoned part way
        fill_left = $urandom_range(3, 12);
        send_cmd(lprq_pkg::OP_PUSH, BYTE_W'(fill_left), 1'b1, LEN_W'(fill_left));
        repeat ($urandom_range(0, fill_left - 2))
          send_cmd(lprq_pkg::OP_PUSH, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
      end else if (roll < 89) begin
        send_cmd(lprq_pkg::OP_PUSH, BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
      end else if (roll < 92) begin
        send_cmd(lprq_pkg::OP_CLEAR, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      end else if (roll < 94) begin
        send_cmd(OP_NOP, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      end else begin
        send_cmd(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom),
                 LEN_W'($urandom));
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
